>>> design/gia_pkg.sv
// Package for the generational handle allocator: sizes, command codes,
// internal operation codes and the queue item and status types.
// Used by every module of the design; depends on nothing.
package gia_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VER_W     = 12;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_DESTROY,
    OP_CHECK,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> design/generational_id_allocator.sv
// Generational handle allocator. The back end registers the result of an item straight
// from its idle state for a fresh create, unknown command or out-of-range handle; a
// destroy or check first reads the slot, and a create that reuses a freed slot first
// reads the stack, then the slot. The back end handles one item at a time; a
// two-entry queue lets the port take items meanwhile.
// Reset clears the counters, queue and strobe; the memories need no clearing.
module generational_id_allocator import gia_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] command_i,
  input  logic [IDX_W-1:0] handle_index_i,
  input  logic [VER_W-1:0] handle_version_i,
  output logic             res_strobe_o,
  output logic [IDX_W-1:0] out_index_o,
  output logic [VER_W-1:0] out_version_o,
  output logic             success_o,
  output logic             full_res_o
);

  logic    push;
  logic    pop;
  item_t   front_item;
  item_t   queue_item;
  q_stat_t q_stat;

  gia_front u_front (
    .start            (start),
    .q_full_i         (q_stat.full),
    .command_i        (command_i),
    .handle_index_i   (handle_index_i),
    .handle_version_i (handle_version_i),
    .busy             (busy),
    .push_o           (push),
    .item_o           (front_item)
  );

  gia_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  gia_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (queue_item),
    .stat_i        (q_stat),
    .pop_o         (pop),
    .res_strobe_o  (res_strobe_o),
    .out_index_o   (out_index_o),
    .out_version_o (out_version_o),
    .success_o     (success_o),
    .full_res_o    (full_res_o)
  );

endmodule

>>> design/gia_front.sv
// Front end of the allocator: takes items on the command port and decodes
// the command into an internal operation. Depends on gia_pkg.
module gia_front import gia_pkg::*; (
  input  logic              start,
  input  logic              q_full_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [IDX_W-1:0]  handle_index_i,
  input  logic [VER_W-1:0]  handle_version_i,
  output logic              busy,
  output logic              push_o,
  output item_t             item_o
);

  op_e op;

  always_comb begin
    case (command_i)
      CMD_CREATE:  op = OP_CREATE;
      CMD_DESTROY: op = OP_DESTROY;
      CMD_CHECK:   op = OP_CHECK;
      default:     op = OP_NONE;
    endcase
  end

  assign busy       = q_full_i;
  assign push_o     = start && !q_full_i;
  assign item_o.op  = op;
  assign item_o.idx = handle_index_i;
  assign item_o.ver = handle_version_i;

endmodule

>>> design/gia_queue.sv
// Two-entry item queue between the front end and the back end.
// Depends on gia_pkg.
module gia_queue import gia_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.full  = (count_q == 2'd2);

endmodule

>>> design/gia_back.sv
// Back end of the allocator: holds the slot version memory, the free stack
// and the counters, and carries out one queued item at a time.
// Depends on gia_pkg.
module gia_back import gia_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  q_stat_t          stat_i,
  output logic             pop_o,
  output logic             res_strobe_o,
  output logic [IDX_W-1:0] out_index_o,
  output logic [VER_W-1:0] out_version_o,
  output logic             success_o,
  output logic             full_res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STK  = 2'd1;
  localparam logic [1:0] ST_SLOT = 2'd2;

  // Each slot word holds a live bit above the version. A slot is written
  // when it is first opened, so only opened slots are ever read.
  logic [VER_W:0]   slot_mem [MAX_SLOTS];
  logic [IDX_W-1:0] stk_mem  [MAX_SLOTS];

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] fc_q, fc_d;
  logic [CNT_W-1:0] ic_q, ic_d;
  logic [CNT_W-1:0] fc_m1;
  op_e              op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VER_W-1:0] ver_q, ver_d;

  logic             strobe_q, strobe_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [VER_W-1:0] over_q, over_d;
  logic             ok_q, ok_d;
  logic             full_q, full_d;

  logic             slot_re, slot_we;
  logic [IDX_W-1:0] slot_raddr, slot_waddr;
  logic [VER_W:0]   slot_wdata, slot_rd_q;
  logic             stk_re, stk_we;
  logic [IDX_W-1:0] stk_raddr, stk_waddr, stk_wdata, stk_rd_q;

  logic             live;
  logic [VER_W-1:0] cur_ver;
  logic             match;
  logic             kill_ok;

  assign fc_m1   = fc_q - CNT_W'(1);
  assign live    = slot_rd_q[VER_W];
  assign cur_ver = slot_rd_q[VER_W-1:0];
  assign match   = live && (cur_ver == ver_q);
  assign kill_ok = match && (fc_q < CNT_W'(MAX_SLOTS));

  always_comb begin
    state_d    = state_q;
    fc_d       = fc_q;
    ic_d       = ic_q;
    op_d       = op_q;
    idx_d      = idx_q;
    ver_d      = ver_q;
    pop_o      = 1'b0;
    strobe_d   = 1'b0;
    oidx_d     = oidx_q;
    over_d     = over_q;
    ok_d       = ok_q;
    full_d     = full_q;
    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;

    case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          op_d  = item_i.op;
          idx_d = item_i.idx;
          ver_d = item_i.ver;
          case (item_i.op)
            OP_CREATE: begin
              if (fc_q != '0) begin
                stk_re    = 1'b1;
                stk_raddr = fc_m1[IDX_W-1:0];
                fc_d      = fc_m1;
                state_d   = ST_STK;
              end else if (ic_q < CNT_W'(MAX_SLOTS)) begin
                slot_we    = 1'b1;
                slot_waddr = ic_q[IDX_W-1:0];
                slot_wdata = {1'b1, {VER_W{1'b0}}};
                ic_d       = ic_q + CNT_W'(1);
                strobe_d   = 1'b1;
                oidx_d     = ic_q[IDX_W-1:0];
                over_d     = '0;
                ok_d       = 1'b1;
                full_d     = 1'b0;
              end else begin
                strobe_d = 1'b1;
                oidx_d   = '0;
                over_d   = '0;
                ok_d     = 1'b0;
                full_d   = 1'b1;
              end
            end
            OP_DESTROY, OP_CHECK: begin
              if ({1'b0, item_i.idx} < ic_q) begin
                slot_re    = 1'b1;
                slot_raddr = item_i.idx;
                state_d    = ST_SLOT;
              end else begin
                strobe_d = 1'b1;
                oidx_d   = item_i.idx;
                over_d   = item_i.ver;
                ok_d     = 1'b0;
                full_d   = 1'b0;
              end
            end
            default: begin
              strobe_d = 1'b1;
              oidx_d   = item_i.idx;
              over_d   = item_i.ver;
              ok_d     = 1'b0;
              full_d   = 1'b0;
            end
          endcase
        end
      end
      ST_STK: begin
        // The popped slot index is now out of the stack memory.
        slot_re    = 1'b1;
        slot_raddr = stk_rd_q;
        idx_d      = stk_rd_q;
        state_d    = ST_SLOT;
      end
      ST_SLOT: begin
        state_d  = ST_IDLE;
        strobe_d = 1'b1;
        full_d   = 1'b0;
        oidx_d   = idx_q;
        case (op_q)
          OP_CREATE: begin
            slot_we    = 1'b1;
            slot_waddr = idx_q;
            slot_wdata = {1'b1, cur_ver};
            over_d     = cur_ver;
            ok_d       = 1'b1;
          end
          OP_DESTROY: begin
            if (kill_ok) begin
              slot_we    = 1'b1;
              slot_waddr = idx_q;
              slot_wdata = {1'b0, cur_ver + VER_W'(1)};
              stk_we     = 1'b1;
              stk_waddr  = fc_q[IDX_W-1:0];
              stk_wdata  = idx_q;
              fc_d       = fc_q + CNT_W'(1);
            end
            over_d = ver_q;
            ok_d   = kill_ok;
          end
          OP_CHECK: begin
            over_d = ver_q;
            ok_d   = match;
          end
          default: begin
            over_d = ver_q;
            ok_d   = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fc_q     <= '0;
      ic_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fc_q     <= fc_d;
      ic_q     <= ic_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    ver_q  <= ver_d;
    oidx_q <= oidx_d;
    over_q <= over_d;
    ok_q   <= ok_d;
    full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  assign res_strobe_o  = strobe_q;
  assign out_index_o   = oidx_q;
  assign out_version_o = over_q;
  assign success_o     = ok_q;
  assign full_res_o    = full_q;

endmodule

>>> design/gia_checker.sv
// Port-level checker for the generational handle allocator, bound to the
// top level. Depends on gia_pkg.
module gia_checker import gia_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             res_strobe_o,
  input logic [IDX_W-1:0] out_index_o,
  input logic [VER_W-1:0] out_version_o,
  input logic             success_o,
  input logic             full_res_o
);

  // A refused create never reports success.
  a_full_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && full_res_o |-> !success_o)
    else $error("full result also reports success");

  // A refused create hands out the null handle.
  a_full_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && full_res_o |-> (out_index_o == '0) && (out_version_o == '0))
    else $error("full result carries a non-zero handle");

  // The queue can only fill up after an item has been offered.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item offered");

endmodule

bind generational_id_allocator gia_checker u_gia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .res_strobe_o  (res_strobe_o),
  .out_index_o   (out_index_o),
  .out_version_o (out_version_o),
  .success_o     (success_o),
  .full_res_o    (full_res_o)
);
